>>> src/montgomery_modmul_128_top_macros.svh
// Assertion macros for the montgomery_modmul_128 block.
// Each macro expects i_clk, and all but MMM_ASSERT_ALWAYS also i_rst_n, in the scope where it is used.
`ifndef MONTGOMERY_MODMUL_128_TOP_MACROS_SVH
`define MONTGOMERY_MODMUL_128_TOP_MACROS_SVH

// Check that an implication holds in the same cycle, outside reset.
`define MMM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that an implication holds in the next cycle, outside reset.
`define MMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Check an implication at every edge, reset included.
`define MMM_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("reset-time check failed");

`endif

>>> src/mmm_pkg.sv
// Shared types and constants of the Montgomery multiplier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmm_pkg;

    localparam int unsigned HALF_W  = 64;
    localparam int unsigned TOP_W   = 63;
    localparam int unsigned WORD_W  = 128;
    localparam int unsigned PROD_W  = 256;
    localparam int unsigned LIMB_W  = 32;
    localparam int unsigned LIMBS   = 4;
    localparam int unsigned ROW_W   = 160;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned MUL_LAT = 3;
    localparam int unsigned PHI_DEPTH = 2 * MUL_LAT;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TO_MONT   = 2'd0,
        FUNC_MUL       = 2'd1,
        FUNC_FROM_MONT = 2'd2,
        FUNC_SPARE     = 2'd3
    } t_func;

    typedef enum logic [IDX_W-1:0] {
        CFG_MOD_HI = 3'd0,
        CFG_MOD_LO = 3'd1,
        CFG_INV_HI = 3'd2,
        CFG_INV_LO = 3'd3,
        CFG_R2_HI  = 3'd4,
        CFG_R2_LO  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] modulus;
        logic [WORD_W-1:0] inverse;
        logic [WORD_W-1:0] rsquare;
    } t_cfg;

endpackage

`default_nettype wire

>>> src/mmm_ifs.sv
// Handshake interfaces for operand, result and configuration channels.
// Depends on mmm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mmm_in_if;
    logic                          valid;
    logic                          ready;
    logic [mmm_pkg::FUNC_W-1:0]    func;
    logic [mmm_pkg::TOP_W-1:0]     a_hi;
    logic [mmm_pkg::HALF_W-1:0]    a_lo;
    logic [mmm_pkg::TOP_W-1:0]     b_hi;
    logic [mmm_pkg::HALF_W-1:0]    b_lo;
    modport source (output valid, func, a_hi, a_lo, b_hi, b_lo, input ready);
    modport sink   (input valid, func, a_hi, a_lo, b_hi, b_lo, output ready);
endinterface

interface mmm_out_if;
    logic                          valid;
    logic                          ready;
    logic [mmm_pkg::TOP_W-1:0]     result_hi;
    logic [mmm_pkg::HALF_W-1:0]    result_lo;
    modport source (output valid, result_hi, result_lo, input ready);
    modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

interface mmm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mmm_pkg::IDX_W-1:0]     index;
    logic [mmm_pkg::HALF_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/mmm_cfg.sv
// Configuration register file: modulus, its inverse and R^2 mod n.
// Depends on mmm_pkg and mmm_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module mmm_cfg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    mmm_cfg_if.sink          i_cfg,
    output mmm_pkg::t_cfg    o_cfg
);

    mmm_pkg::t_cfg r_cfg;
    logic          w_wr;

    // Accept a write in every cycle
    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;
    assign o_cfg       = r_cfg;

    // Load the addressed half; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.modulus <= mmm_pkg::WORD_W'(1);
            r_cfg.inverse <= mmm_pkg::WORD_W'(1);
            r_cfg.rsquare <= '0;
        end else if (w_wr) begin
            case (mmm_pkg::t_cfg_idx'(i_cfg.index))
                mmm_pkg::CFG_MOD_HI: r_cfg.modulus[127:64] <= {1'b0, i_cfg.data[62:0]};
                mmm_pkg::CFG_MOD_LO: r_cfg.modulus[63:0]   <= i_cfg.data;
                mmm_pkg::CFG_INV_HI: r_cfg.inverse[127:64] <= i_cfg.data;
                mmm_pkg::CFG_INV_LO: r_cfg.inverse[63:0]   <= i_cfg.data;
                mmm_pkg::CFG_R2_HI:  r_cfg.rsquare[127:64] <= {1'b0, i_cfg.data[62:0]};
                mmm_pkg::CFG_R2_LO:  r_cfg.rsquare[63:0]   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/mmm_mul128.sv
// Three-stage pipelined 128 x 128 -> 256 bit multiplier built from 32-bit limbs.
// Depends on mmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmm_mul128 (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire  [mmm_pkg::WORD_W-1:0]   i_x,
    input  wire  [mmm_pkg::WORD_W-1:0]   i_y,
    output logic                         o_valid,
    output logic [mmm_pkg::PROD_W-1:0]   o_prod
);

    localparam int unsigned LW = mmm_pkg::LIMB_W;
    localparam int unsigned NL = mmm_pkg::LIMBS;

    logic [2*LW-1:0]             r_pp  [NL][NL];
    logic [mmm_pkg::ROW_W-1:0]   r_row [NL];
    logic [mmm_pkg::PROD_W-1:0]  r_prod;
    logic [mmm_pkg::MUL_LAT-1:0] r_valid;
    logic [mmm_pkg::ROW_W-1:0]   n_row [NL];
    logic [mmm_pkg::PROD_W-1:0]  n_prod;

    // Sum each row of partial products into one shifted row value
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NL; j++) begin
                n_row[i] = n_row[i] + (mmm_pkg::ROW_W'(r_pp[i][j]) << (LW * j));
            end
        end
    end

    // Sum the rows into the full product
    always_comb begin
        n_prod = '0;
        for (int i = 0; i < NL; i++) begin
            n_prod = n_prod + (mmm_pkg::PROD_W'(r_row[i]) << (LW * i));
        end
    end

    // Advance the data stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    r_pp[i][j] <= i_x[LW*i +: LW] * i_y[LW*j +: LW];
                end
                r_row[i] <= n_row[i];
            end
            r_prod <= n_prod;
        end
    end

    // Carry the valid bits alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[mmm_pkg::MUL_LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_valid[mmm_pkg::MUL_LAT-1];
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

>>> src/montgomery_modmul_128_top.sv
// Montgomery modular multiplier top level: operand select, three multipliers, fixup.
// Depends on mmm_pkg, the channel interfaces, mmm_cfg, mmm_mul128 and the macro header.
//
// Usage:
//   i_cfg writes the modulus, its inverse mod 2^128 and R^2 mod n, one 64-bit
//   half per item, register index in index. Write only while the block is idle.
//   i_in takes one operation item per cycle: func 0 converts a to Montgomery
//   form, 1 multiplies a and b, 2 (and 3) converts a back.
//   o_out gives one result item per operation, in order.
// Path from input acceptance to result valid: three three-stage multipliers
//   in series (operand x b, low x inverse, q x n), one subtract stage and
//   one fixup/output stage.
// Throughput: one item per cycle unless the output stalls; the whole pipeline advances as one.
// Reset: synchronous, active low; clears all valid bits and loads the
//   modulus and inverse with one and R^2 with zero.
// Stall: when the result waits and o_out.ready is low, every stage holds and
//   i_in.ready drops in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

`include "montgomery_modmul_128_top_macros.svh"

module montgomery_modmul_128_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mmm_in_if.sink     i_in,
    mmm_out_if.source  o_out,
    mmm_cfg_if.sink    i_cfg
);

    localparam int unsigned W = mmm_pkg::WORD_W;

    mmm_pkg::t_cfg               w_cfg;
    logic                        w_en;
    logic [W-1:0]                w_a;
    logic [W-1:0]                w_b;
    logic                        w_v1;
    logic                        w_v2;
    logic                        w_v3;
    logic [mmm_pkg::PROD_W-1:0]  w_p1;
    logic [mmm_pkg::PROD_W-1:0]  w_p2;
    logic [mmm_pkg::PROD_W-1:0]  w_p3;
    logic [W-1:0]                r_phi [mmm_pkg::PHI_DEPTH];
    logic [W-1:0]                r_sub;
    logic                        r_sub_valid;
    logic [W-1:0]                n_res;
    logic [W-1:0]                r_res;
    logic                        r_out_valid;

    mmm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Advance the whole pipeline unless a finished result is held
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // Pick the second operand from the operation code
    assign w_a = {1'b0, i_in.a_hi, i_in.a_lo};
    always_comb begin
        case (mmm_pkg::t_func'(i_in.func))
            mmm_pkg::FUNC_TO_MONT: w_b = w_cfg.rsquare;
            mmm_pkg::FUNC_MUL:     w_b = {1'b0, i_in.b_hi, i_in.b_lo};
            default:               w_b = W'(1);
        endcase
    end

    mmm_mul128 u_mul_ab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_x     (w_a),
        .i_y     (w_b),
        .o_valid (w_v1),
        .o_prod  (w_p1)
    );

    mmm_mul128 u_mul_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v1),
        .i_x     (w_p1[W-1:0]),
        .i_y     (w_cfg.inverse),
        .o_valid (w_v2),
        .o_prod  (w_p2)
    );

    mmm_mul128 u_mul_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v2),
        .i_x     (w_p2[W-1:0]),
        .i_y     (w_cfg.modulus),
        .o_valid (w_v3),
        .o_prod  (w_p3)
    );

    // Delay the product's high half alongside the two reduction multipliers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_phi[0] <= w_p1[2*W-1:W];
            for (int k = 1; k < mmm_pkg::PHI_DEPTH; k++) begin
                r_phi[k] <= r_phi[k-1];
            end
        end
    end

    // Subtract the high half of q * n, then add n back if negative
    assign n_res = r_sub[W-1] ? (r_sub + w_cfg.modulus) : r_sub;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sub <= r_phi[mmm_pkg::PHI_DEPTH-1] - w_p3[2*W-1:W];
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_sub_valid <= w_v3;
            r_out_valid <= r_sub_valid;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.result_hi = r_res[mmm_pkg::TOP_W-1+mmm_pkg::HALF_W:mmm_pkg::HALF_W];
    assign o_out.result_lo = r_res[mmm_pkg::HALF_W-1:0];

    // A held result blocks new input items
    `MMM_ASSERT_NOW(a_stall_blocks_input, r_out_valid && !o_out.ready, !i_in.ready)
    // A subtracted value moves into the output register when the pipe advances
    `MMM_ASSERT_NEXT(a_sub_reaches_out, r_sub_valid && w_en, o_out.valid)
    // No result is shown on the edge after a reset cycle
    `MMM_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n, ##1 !o_out.valid)

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Testbench for montgomery_modmul_128_top: directed table, then random items.
// Depends on mmm_pkg, the channel interfaces and the block under test.
`timescale 1ns / 1ps

module tb_top;
    import mmm_pkg::*;

    localparam int unsigned N_RANDOM = 1600;

    typedef struct {
        t_func       func;
        logic [62:0] a_hi;
        logic [63:0] a_lo;
        logic [62:0] b_hi;
        logic [63:0] b_lo;
        bit          known;
        logic [62:0] want_hi;
        logic [63:0] want_lo;
    } t_row;

    typedef struct {
        logic [62:0] res_hi;
        logic [63:0] res_lo;
    } t_product;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mmm_in_if  in_ch ();
    mmm_out_if out_ch ();
    mmm_cfg_if cfg_ch ();

    montgomery_modmul_128_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the loaded registers
    logic [127:0] mod_n, inv_n, r2_n;
    t_product     pending_products[$];
    int           fail_count = 0;
    bit           calm = 1'b0;

    // Montgomery reduction of a 256-bit product, as the block does it
    function automatic logic [127:0] redc(input logic [255:0] prod);
        logic [255:0] q;
        logic [255:0] qn;
        logic [127:0] t;
        q  = prod[127:0] * inv_n;
        qn = {128'd0, q[127:0]} * {128'd0, mod_n};
        t  = prod[255:128] - qn[255:128];
        if (t[127]) begin
            t = t + mod_n;
        end
        return t;
    endfunction

    // Operands carry 127 bits; the top bit is dropped as on the ports
    function automatic t_product predict_product(input t_func f, input logic [127:0] a,
                                                 input logic [127:0] b);
        logic [127:0] other;
        logic [255:0] prod;
        logic [127:0] r;
        t_product     p;
        case (f)
            FUNC_TO_MONT: other = r2_n;
            FUNC_MUL:     other = {1'b0, b[126:0]};
            default:      other = 128'd1;
        endcase
        prod = {129'd0, a[126:0]} * {128'd0, other};
        r = redc(prod);
        p.res_hi = r[126:64];
        p.res_lo = r[63:0];
        return p;
    endfunction

    // Input and config drive defaults
    initial begin
        in_ch.valid  = 1'b0;
        in_ch.func   = FUNC_TO_MONT;
        in_ch.a_hi   = '0;
        in_ch.a_lo   = '0;
        in_ch.b_hi   = '0;
        in_ch.b_lo   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_MOD_HI;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
    end

    // Result sink: random stalls, compare against oldest expectation
    always @(posedge i_clk) begin
        t_product e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_products.size() == 0) begin
                $error("result_hi: expected none, actual %h", out_ch.result_hi);
                fail_count++;
            end else begin
                e = pending_products.pop_front();
                if (out_ch.result_hi !== e.res_hi) begin
                    $error("result_hi: expected %h actual %h", e.res_hi, out_ch.result_hi);
                    fail_count++;
                end
                if (out_ch.result_lo !== e.res_lo) begin
                    $error("result_lo: expected %h actual %h", e.res_lo, out_ch.result_lo);
                    fail_count++;
                end
            end
        end
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_MOD_HI: mod_n[127:64] = {1'b0, value[62:0]};
            CFG_MOD_LO: mod_n[63:0]   = value;
            CFG_INV_HI: inv_n[127:64] = value;
            CFG_INV_LO: inv_n[63:0]   = value;
            CFG_R2_HI:  r2_n[127:64]  = {1'b0, value[62:0]};
            default:    r2_n[63:0]    = value;
        endcase
    endtask

    // Load n, n^-1 mod 2^128 and R^2 mod n
    task automatic load_modulus(input logic [127:0] n);
        logic [127:0] inv;
        logic [255:0] r2;
        inv = n;
        repeat (7) inv = inv * (128'd2 - n * inv);
        r2 = (256'd1 << 255) % {128'd0, n};
        r2 = (r2 * 2) % {128'd0, n};
        write_reg(CFG_MOD_HI, n[127:64]);
        write_reg(CFG_MOD_LO, n[63:0]);
        write_reg(CFG_INV_HI, inv[127:64]);
        write_reg(CFG_INV_LO, inv[63:0]);
        write_reg(CFG_R2_HI, r2[127:64]);
        write_reg(CFG_R2_LO, r2[63:0]);
    endtask

    // Hand one item over; pending valid stays high across back-to-back items
    task automatic send_item(input t_func f, input logic [127:0] a, input logic [127:0] b,
                             input bit gaps);
        while (gaps && !calm && $urandom_range(99) < 27) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= f;
        in_ch.a_hi  <= a[126:64];
        in_ch.a_lo  <= a[63:0];
        in_ch.b_hi  <= b[126:64];
        in_ch.b_lo  <= b[63:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_products.insert(pending_products.size(), predict_product(f, a, b));
    endtask

    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    function automatic logic [127:0] rand_below(input logic [127:0] n);
        logic [127:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(9) == 0) return n - 1;
        if ($urandom_range(9) == 0) return 128'($urandom_range(3));
        return v % n;
    endfunction

    function automatic logic [127:0] rand_odd(input int kind);
        logic [127:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        v[127] = 1'b0;
        case (kind)
            0: v = {65'd0, v[62:0]};
            1: v = (128'd1 << 127) - 1;
            2: v = 128'd3;
            default: ;
        endcase
        v[0] = 1'b1;
        return v;
    endfunction

    initial begin
        t_row          rows[$];
        t_row          r;
        t_product      got;
        logic [127:0]  n, a, b;

        // Registers after reset
        mod_n = 128'd1;
        inv_n = 128'd1;
        r2_n  = 128'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset modulus of one: the reduction leaves the high half of the product
        rows.insert(rows.size(), '{FUNC_TO_MONT, '1, '1, '0, '0, 1'b1, '0, '0});
        rows.insert(rows.size(), '{FUNC_MUL, '1, '1, '1, '1, 1'b1,
                                   63'h3FFF_FFFF_FFFF_FFFF, '1});
        rows.insert(rows.size(), '{FUNC_SPARE, '0, 64'd5, '1, '1, 1'b1, '0, '0});
        foreach (rows[i]) begin
            r = rows[i];
            send_item(r.func, {1'b0, r.a_hi, r.a_lo}, {1'b0, r.b_hi, r.b_lo}, 1'b0);
            got = pending_products[$];
            if (r.known && (got.res_hi !== r.want_hi || got.res_lo !== r.want_lo)) begin
                $error("table row %0d: prediction off", i);
                fail_count++;
            end
        end
        drain_pipe();

        // Largest odd modulus, then extremes of operands incl. unused func and n itself
        n = (128'd1 << 127) - 1;
        load_modulus(n);
        rows.delete();
        rows.insert(rows.size(), '{FUNC_TO_MONT, '0, '0, '0, '0, 1'b1, '0, '0});
        rows.insert(rows.size(), '{FUNC_FROM_MONT, '0, '0, '1, '1, 1'b1, '0, '0});
        rows.insert(rows.size(), '{FUNC_MUL, '0, '0, '1, '1, 1'b1, '0, '0});
        rows.insert(rows.size(), '{FUNC_TO_MONT, n[126:64], n[63:0] - 1, '0, '0,
                                   1'b0, '0, '0});
        rows.insert(rows.size(), '{FUNC_MUL, n[126:64], n[63:0] - 1, n[126:64],
                                   n[63:0] - 1, 1'b0, '0, '0});
        rows.insert(rows.size(), '{FUNC_FROM_MONT, n[126:64], n[63:0] - 1, '0, '0,
                                   1'b0, '0, '0});
        rows.insert(rows.size(), '{FUNC_SPARE, '0, 64'd1, '1, '1, 1'b0, '0, '0});
        rows.insert(rows.size(), '{FUNC_MUL, '1, '1, '1, '1, 1'b0, '0, '0});
        rows.insert(rows.size(), '{FUNC_TO_MONT, '1, '1, '0, '0, 1'b0, '0, '0});
        foreach (rows[i]) begin
            r = rows[i];
            send_item(r.func, {1'b0, r.a_hi, r.a_lo}, {1'b0, r.b_hi, r.b_lo}, 1'b0);
        end
        drain_pipe();

        // Even modulus with garbage inverse: results still checked, same arithmetic
        write_reg(CFG_MOD_LO, 64'hFFFF_0000_1234_5678);
        write_reg(CFG_INV_HI, '1);
        write_reg(CFG_R2_HI, '1);
        for (int i = 0; i < 6; i++)
            send_item(t_func'(i % 4), {$urandom, $urandom, $urandom, $urandom},
                      {$urandom, $urandom, $urandom, $urandom}, 1'b1);
        drain_pipe();

        // Random phases with several moduli
        for (int ph = 0; ph < 8; ph++) begin
            n = rand_odd(ph % 4);
            load_modulus(n);
            for (int i = 0; i < N_RANDOM / 8; i++) begin
                calm = (ph == 3);
                a = rand_below(n);
                b = rand_below(n);
                if ($urandom_range(19) == 0) begin
                    a[126:0] = 127'({$urandom, $urandom, $urandom, $urandom});
                    b[126:0] = 127'({$urandom, $urandom, $urandom, $urandom});
                end
                send_item(t_func'($urandom_range(3)), a, b, 1'b1);
            end
            calm = 1'b0;
            drain_pipe();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop on hang
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

>>> montgomery_modmul_128_top.f
+incdir+src
src/mmm_pkg.sv
src/mmm_ifs.sv
src/mmm_cfg.sv
src/mmm_mul128.sv
src/montgomery_modmul_128_top.sv
test/tb_top.sv
